[src/multi_domain_clock_event_scheduler_defines.svh]
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Shared property shorthands for the scheduler checker.
// ----------------------------------------------------------------------------
`ifndef MULTI_DOMAIN_CLOCK_EVENT_SCHEDULER_DEFINES_SVH
`define MULTI_DOMAIN_CLOCK_EVENT_SCHEDULER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define MDCES_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mdces check failed");

// next-cycle implication, disabled while reset is asserted
`define MDCES_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mdces check failed");

`endif

[src/mdces_pkg.sv]
// ----------------------------------------------------------------------------
// Scheduler package
// Constants, codes and handshake structs shared by the scheduler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mdces_pkg;

  localparam int unsigned AccW   = 32;
  localparam int unsigned ClkW   = 26;
  localparam int unsigned StepsW = 6;

  // actions carried in the input tuser
  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_VIDEO = 2'd1;
  localparam logic [1:0] ACT_SOUND = 2'd2;
  localparam logic [1:0] ACT_TIMER = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_CPU_HZ      = 2'd0;
  localparam logic [1:0] CFG_TIMER_DELAY = 2'd1;
  localparam logic [1:0] CFG_FRAME_LINES = 2'd2;

  localparam logic [ClkW-1:0] CPU_HZ_RST      = 26'd10000000;
  localparam logic [15:0]     TIMER_DELAY_RST = 16'd0;
  localparam logic [9:0]      FRAME_LINES_RST = 10'd526;

  localparam logic [AccW-1:0] ONE_PERIOD = 32'h0100_0000;
  localparam logic [AccW-1:0] SOUND_RATE = 32'd44100;
  localparam logic [AccW-1:0] TIMER_BASE = 32'd21000000;

  // full-width quotient, and a short run for 11-bit line values
  localparam logic [StepsW-1:0] DIV_STEPS_FULL = 6'd32;
  localparam logic [StepsW-1:0] DIV_STEPS_LINE = 6'd11;

  typedef struct packed {
    logic              start;
    logic [AccW-1:0]   dividend;
    logic [ClkW-1:0]   divisor;
    logic [StepsW-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [AccW-1:0] quo;
    logic [ClkW-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

[src/mdces_div.sv]
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring divider, one quotient bit per cycle; the dividend is left
// aligned by the caller and the run length sets how many bits are produced.
// ----------------------------------------------------------------------------
`default_nettype none

module mdces_div
  import mdces_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [StepsW-1:0] cnt_q, cnt_d;
  logic [ClkW-1:0]   rem_q, rem_d;
  logic [AccW-1:0]   quo_q, quo_d;
  logic [ClkW-1:0]   dsr_q, dsr_d;
  logic [ClkW:0]     shifted;
  logic [ClkW+1:0]   trial;

  assign shifted = {rem_q, quo_q[AccW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      // no borrow means the divisor fits
      if (!trial[ClkW+1]) begin
        rem_d = trial[ClkW-1:0];
        quo_d = {quo_q[AccW-2:0], 1'b1};
      end else begin
        rem_d = shifted[ClkW-1:0];
        quo_d = {quo_q[AccW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == StepsW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

[src/mdces_mac.sv]
// ----------------------------------------------------------------------------
// Multiply-accumulate unit
// Registered c + a*b, wrapping at 32 bits; shared by the accumulator advances of a push.
// ----------------------------------------------------------------------------
`default_nettype none

module mdces_mac
  import mdces_pkg::*;
(
  input  logic            clk_i,
  input  logic [AccW-1:0] a_i,
  input  logic [AccW-1:0] b_i,
  input  logic [AccW-1:0] c_i,
  output logic [AccW-1:0] res_o
);

  logic [AccW-1:0] prod_lo;
  logic [AccW-1:0] res_q, res_d;

  // only the low word of the product is kept
  assign prod_lo = a_i * b_i;
  assign res_d   = c_i + prod_lo;

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

[src/multi_domain_clock_event_scheduler.sv]
// ----------------------------------------------------------------------------
// Multi-domain clock event scheduler
// Phase-accumulator divider: cpu cycles advance video, sound and timer
// accumulators; take actions pop one period per event.
// ----------------------------------------------------------------------------
// Usage: items enter on the s_axis channel, tuser holding the action (push
// cycles, take video, take sound, take timer) and tdata the cycle count.
// Every item gives one result on m_axis: tuser is the event flag, tdata the
// line within the half frame, the half-frame index and the raw line.
// Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i while idle;
// the user is bound to this, the block does not enforce it. A push result
// comes from a 32-step divide of the cycle count's low byte by the cpu clock
// rate, run beside the timer rate divide, then four passes through the shared
// multiply-add, then an 11-step line divide. A take result comes from an
// 11-step line divide, after an extra 11-step divide when a video event
// advances the line counter. The divider is the bound; one item is in work
// at once. The result sits in an output register; the next item is taken
// while it waits, and a stalled receiver holds the block only when a second
// result is ready. Reset restores the register defaults and clears the
// control state and accumulators; datapath registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_domain_clock_event_scheduler
  import mdces_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [25:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // cycle_count
  input  logic [1:0]  s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // line_in_half, half_frame, raw_line, zero pad
  output logic [0:0]  m_axis_tuser   // event_ready
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DIV   = 4'd1;
  localparam logic [3:0] ST_CPU   = 4'd2;
  localparam logic [3:0] ST_FIX   = 4'd3;
  localparam logic [3:0] ST_VID   = 4'd4;
  localparam logic [3:0] ST_SND   = 4'd5;
  localparam logic [3:0] ST_TMR   = 4'd6;
  localparam logic [3:0] ST_TWB   = 4'd7;
  localparam logic [3:0] ST_MOD   = 4'd8;
  localparam logic [3:0] ST_LWAIT = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;

  logic [3:0]      state_q;
  logic [ClkW-1:0] cpu_hz_q;
  logic [15:0]     timer_delay_q;
  logic [9:0]      frame_lines_q;
  logic [AccW-1:0] cpu_q, video_q, sound_q, timer_q;
  logic [9:0]      line_q;
  logic [15:0]     clks_q;
  logic [AccW-1:0] arm_q, tq_q;
  logic            ev_q;
  logic            out_valid_q, out_ev_q;
  logic [8:0]      out_lih_q;
  logic [1:0]      out_hf_q;
  logic [9:0]      out_raw_q;

  logic            in_acc;
  logic [ClkW-1:0] eff_clk;
  logic [9:0]      eff_lines;
  logic [8:0]      half_lines;
  logic [14:0]     line_fac;
  logic [10:0]     line_inc;
  logic [9:0]      line_src;
  logic            line_div;
  logic [AccW-1:0] cpu_fix;
  logic            need_fix;
  logic            out_free;

  div_req_t        div_a_req, div_b_req;
  div_rsp_t        div_a_rsp, div_b_rsp;
  logic [AccW-1:0] mac_a, mac_b, mac_c, mac_res;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign eff_clk    = (cpu_hz_q == '0) ? ClkW'(1) : cpu_hz_q;
  assign eff_lines  = (frame_lines_q < 10'd2) ? 10'd2 : frame_lines_q;
  assign half_lines = eff_lines[9:1];
  // lines * 30 as lines*32 - lines*2
  assign line_fac   = {eff_lines, 5'b0} - {4'b0, eff_lines, 1'b0};
  assign line_inc   = {1'b0, line_q} + 11'd1;

  assign cpu_fix  = mac_res + {6'b0, eff_clk};
  assign need_fix = ({8'b0, mac_res[31:24]} != clks_q);

  // divider A: quantization, line wrap and the line split for the result
  always_comb begin
    line_div = 1'b0;
    line_src = line_q;
    div_a_req = '0;
    if (in_acc) begin
      if (s_axis_tuser == ACT_PUSH) begin
        div_a_req.start    = 1'b1;
        div_a_req.dividend = {s_axis_tdata[7:0], 24'b0};
        div_a_req.divisor  = eff_clk;
        div_a_req.steps    = DIV_STEPS_FULL;
      end else if (s_axis_tuser == ACT_VIDEO && video_q[31:24] != '0) begin
        div_a_req.start    = 1'b1;
        div_a_req.dividend = {line_inc, 21'b0};
        div_a_req.divisor  = {16'b0, eff_lines};
        div_a_req.steps    = DIV_STEPS_LINE;
      end else begin
        line_div = 1'b1;
      end
    end else if (state_q == ST_MOD && div_a_rsp.done) begin
      line_div = 1'b1;
      line_src = div_a_rsp.rem[9:0];
    end else if (state_q == ST_TWB) begin
      line_div = 1'b1;
    end
    if (line_div) begin
      div_a_req.start    = 1'b1;
      div_a_req.dividend = {1'b0, line_src, 21'b0};
      div_a_req.divisor  = {17'b0, half_lines};
      div_a_req.steps    = DIV_STEPS_LINE;
    end
  end

  // divider B: timer rate, alongside the quantization
  always_comb begin
    div_b_req = '0;
    if (in_acc && s_axis_tuser == ACT_PUSH) begin
      div_b_req.start    = 1'b1;
      div_b_req.dividend = TIMER_BASE;
      div_b_req.divisor  = {10'b0, timer_delay_q};
      div_b_req.steps    = DIV_STEPS_FULL;
    end
  end

  always_comb begin
    mac_a = arm_q;
    mac_b = '0;
    mac_c = '0;
    unique case (state_q)
      ST_CPU: begin
        mac_b = {6'b0, eff_clk};
        mac_c = cpu_q;
      end
      ST_VID: begin
        mac_b = {17'b0, line_fac};
        mac_c = video_q;
      end
      ST_SND: begin
        mac_b = SOUND_RATE;
        mac_c = sound_q;
      end
      ST_TMR: begin
        mac_b = tq_q;
        mac_c = timer_q;
      end
      default: begin
        mac_b = '0;
        mac_c = '0;
      end
    endcase
  end

  mdces_div u_div_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_a_req),
    .rsp_o  (div_a_rsp)
  );

  mdces_div u_div_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_b_req),
    .rsp_o  (div_b_rsp)
  );

  mdces_mac u_mac (
    .clk_i (clk_i),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .c_i   (mac_c),
    .res_o (mac_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_hz_q      <= CPU_HZ_RST;
      timer_delay_q <= TIMER_DELAY_RST;
      frame_lines_q <= FRAME_LINES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CPU_HZ:      cpu_hz_q      <= cfg_data_i;
        CFG_TIMER_DELAY: timer_delay_q <= cfg_data_i[15:0];
        CFG_FRAME_LINES: frame_lines_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cpu_q       <= '0;
      video_q     <= '0;
      sound_q     <= '0;
      timer_q     <= '0;
      line_q      <= '0;
      ev_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (s_axis_tuser)
              ACT_PUSH: begin
                ev_q    <= 1'b0;
                state_q <= ST_DIV;
              end
              ACT_VIDEO: begin
                if (video_q[31:24] != '0) begin
                  video_q <= video_q - ONE_PERIOD;
                  ev_q    <= 1'b1;
                  state_q <= ST_MOD;
                end else begin
                  ev_q    <= 1'b0;
                  state_q <= ST_LWAIT;
                end
              end
              ACT_SOUND: begin
                if (sound_q[31:24] != '0) begin
                  sound_q <= sound_q - ONE_PERIOD;
                end
                ev_q    <= (sound_q[31:24] != '0);
                state_q <= ST_LWAIT;
              end
              ACT_TIMER: begin
                if (timer_q[31:24] != '0) begin
                  timer_q <= timer_q - ONE_PERIOD;
                end
                ev_q    <= (timer_q[31:24] != '0);
                state_q <= ST_LWAIT;
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          if (div_a_rsp.done) begin
            state_q <= ST_CPU;
          end
        end
        ST_CPU: state_q <= ST_FIX;
        ST_FIX: begin
          // remainder drifted off the pushed count: one more quantum
          if (need_fix) begin
            cpu_q <= {8'b0, cpu_fix[23:0]};
          end else begin
            cpu_q <= mac_res;
          end
          state_q <= ST_VID;
        end
        ST_VID: state_q <= ST_SND;
        ST_SND: begin
          video_q <= mac_res;
          state_q <= ST_TMR;
        end
        ST_TMR: begin
          sound_q <= mac_res;
          state_q <= ST_TWB;
        end
        ST_TWB: begin
          if (timer_delay_q != '0) begin
            timer_q <= mac_res;
          end
          state_q <= ST_LWAIT;
        end
        ST_MOD: begin
          if (div_a_rsp.done) begin
            line_q  <= div_a_rsp.rem[9:0];
            state_q <= ST_LWAIT;
          end
        end
        ST_LWAIT: begin
          if (div_a_rsp.done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      clks_q <= s_axis_tdata;
    end
    if (state_q == ST_DIV && div_a_rsp.done) begin
      arm_q <= div_a_rsp.quo;
      tq_q  <= div_b_rsp.quo;
    end else if (state_q == ST_FIX && need_fix) begin
      arm_q <= arm_q + 32'd1;
    end
    if (state_q == ST_OUT && out_free) begin
      out_ev_q  <= ev_q;
      out_lih_q <= div_a_rsp.rem[8:0];
      out_hf_q  <= div_a_rsp.quo[1:0];
      out_raw_q <= line_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_ev_q;
  assign m_axis_tdata  = {3'b0, out_raw_q, out_hf_q, out_lih_q};

endmodule

`default_nettype wire

[src/mdces_chk.sv]
// ----------------------------------------------------------------------------
// Scheduler port checker
// Watches the scheduler ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_domain_clock_event_scheduler_defines.svh"

module mdces_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser
);

  // a stalled result holds
  `MDCES_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // an accepted item keeps the block busy for at least the next cycle
  `MDCES_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // the line counter never reaches the top code
  `MDCES_ASSERT_IMP(a_raw_line_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[20:11] != 10'h3ff)

  // pad bits above the result fields stay zero
  `MDCES_ASSERT_IMP(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[23:21] == 3'b000)

endmodule

bind multi_domain_clock_event_scheduler mdces_chk u_mdces_chk (.*);

`default_nettype wire
